### rtl/rolling_sigma_motion_gate_top_macros.svh
// assertion macros for the rolling sigma motion gate
// needs a clock named clk and a reset named rst in the module that uses them
`ifndef ROLLING_SIGMA_MOTION_GATE_TOP_MACROS_SVH
`define ROLLING_SIGMA_MOTION_GATE_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define RSMG_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rsmg assertion failed");

// next-cycle implication, off during reset
`define RSMG_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rsmg assertion failed");

`endif

### rtl/rsmg_pkg.sv
// shared types, constants and register codes for the rolling sigma motion gate
// no dependencies
package rsmg_pkg;

  localparam int DEF_MAX_WINDOW  = 128;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int WL_W       = 8;
  localparam int THR_W      = 16;
  localparam int HOLD_W     = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int MIN_SPREAD_N = 2;

  localparam logic [WL_W-1:0]   RST_WINDOW_LENGTH = 8'd64;
  localparam logic [THR_W-1:0]  RST_ENTER_THR     = 16'd1000;
  localparam logic [THR_W-1:0]  RST_EXIT_THR      = 16'd500;
  localparam logic [HOLD_W-1:0] RST_EXIT_HOLD     = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_ENTER_THR     = 2'd1,
    REG_EXIT_THR      = 2'd2,
    REG_EXIT_HOLD     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WL_W-1:0]   window_length;
    logic [THR_W-1:0]  enter_level;
    logic [THR_W-1:0]  exit_level;
    logic [HOLD_W-1:0] exit_hold;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_MUL,
    ST_CMP
  } core_state_t;

endpackage

### rtl/rsmg_ram.sv
// generic single-port ram with registered read
// no dependencies
module rsmg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/rsmg_front.sv
// front end: takes input beats, splits clear from sample, two-entry queue
// depends on rsmg_pkg
module rsmg_front #(
  parameter int SAMPLE_BITS = rsmg_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          op,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          head_valid,
  output logic                          head_clear,
  output logic signed [SAMPLE_BITS-1:0] head_sample,
  input  logic                          head_pop
);

  localparam int ENT_W = SAMPLE_BITS + 1;

  logic [ENT_W-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;
  logic [ENT_W-1:0] head;

  assign item_stall = (count == 2'd2);
  assign push       = item_valid && !item_stall;
  assign pop        = head_pop && (count != 2'd0);

  assign head        = slot[rd_ptr];
  assign head_valid  = (count != 2'd0);
  assign head_clear  = head[ENT_W-1];
  assign head_sample = $signed(head[SAMPLE_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= {op, sample};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/rsmg_core.sv
// back end: sample ring, running sums, spread compare, hysteresis and result register
// depends on rsmg_pkg, rsmg_ram and the assertion macro header
`include "rolling_sigma_motion_gate_top_macros.svh"

module rsmg_core #(
  parameter int MAX_WINDOW  = rsmg_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = rsmg_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rsmg_pkg::cfg_t                cfg,
  input  logic                          head_valid,
  input  logic                          head_clear,
  input  logic signed [SAMPLE_BITS-1:0] head_sample,
  output logic                          head_pop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          motion_on,
  output logic [rsmg_pkg::CNT_W-1:0]    motion_count,
  output logic [rsmg_pkg::CNT_W-1:0]    total_count
);

  localparam int POS_W   = $clog2(MAX_WINDOW);
  localparam int PW1     = POS_W + 1;
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SAMPLE_BITS + POS_W + 1;
  localparam int SQ_W    = 2 * SAMPLE_BITS + POS_W;
  localparam int XSQ_W   = 2 * SAMPLE_BITS;
  localparam int NQ_W    = SQ_W + WIN_W;
  localparam int MSQ_W   = 2 * SUM_W;
  localparam int TN_W    = rsmg_pkg::THR_W + WIN_W;
  localparam int TNSQ_W  = 2 * TN_W;
  localparam int LIM_W   = ((MSQ_W > TNSQ_W) ? MSQ_W : TNSQ_W) + 1;
  localparam int CMP_W   = (NQ_W > LIM_W) ? NQ_W : LIM_W;
  localparam int HOLD_W  = rsmg_pkg::HOLD_W;
  localparam int CNT_W   = rsmg_pkg::CNT_W;
  localparam int WL_W    = rsmg_pkg::WL_W;

  rsmg_pkg::core_state_t state, state_next;

  // architectural state
  logic [POS_W-1:0]        position;
  logic                    window_full;
  logic signed [SUM_W-1:0] running_sum;
  logic [SQ_W-1:0]         running_sq;
  logic [HOLD_W-1:0]       quiet_run;
  logic                    motion_flag;
  logic [CNT_W-1:0]        motion_samples;
  logic [CNT_W-1:0]        all_samples;
  // entries below this mark were written since the last clear
  logic [PW1-1:0]          fill_count;

  // per-sample working registers
  logic signed [SAMPLE_BITS-1:0] x;
  logic [XSQ_W-1:0]        xsq;
  logic [XSQ_W-1:0]        old_sq;
  logic [POS_W-1:0]        pos_adv;
  logic                    full_adv;
  logic [WIN_W-1:0]        n;
  logic [TN_W-1:0]         tn;
  logic [TNSQ_W-1:0]       tnsq;
  logic [MSQ_W-1:0]        magsq;
  logic [NQ_W-1:0]         nq;
  logic [CMP_W-1:0]        lim;

  logic                    ram_we;
  logic signed [SAMPLE_BITS-1:0] ram_rdata;
  logic                    load_out;
  logic                    do_clear;
  logic                    out_busy;

  logic [WIN_W-1:0]        win;
  logic [PW1-1:0]          pos_inc;
  logic                    wrap;
  logic [WIN_W-1:0]        n_calc;
  logic [rsmg_pkg::THR_W-1:0] thr_sel;
  logic                    old_ok;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic signed [XSQ_W-1:0] x_sq_full;
  logic signed [XSQ_W-1:0] old_sq_full;
  logic [SUM_W-1:0]        mag;
  logic                    sigma_ge;
  logic                    n_ok;
  logic [HOLD_W-1:0]       quiet_inc;
  logic                    flag_next;
  logic [HOLD_W-1:0]       quiet_next;
  logic [CNT_W-1:0]        motion_next;
  logic [CNT_W-1:0]        all_next;

  rsmg_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .addr (position),
    .wdata(x),
    .rdata(ram_rdata)
  );

  assign out_busy = result_valid && result_stall;

  // effective window: zero acts as one, clipped to the ring depth
  always_comb begin
    if (cfg.window_length == '0) begin
      win = WIN_W'(1);
    end else if ({{(32-WL_W){1'b0}}, cfg.window_length} > 32'(MAX_WINDOW)) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(cfg.window_length);
    end
  end

  assign pos_inc = {1'b0, position} + PW1'(1);
  assign wrap    = (pos_inc >= PW1'(win));
  assign n_calc  = (window_full || wrap) ? win : WIN_W'(pos_inc);
  assign thr_sel = motion_flag ? cfg.exit_level : cfg.enter_level;

  // an entry past the fill mark counts as zero
  assign old_ok     = ({1'b0, position} < fill_count);
  assign old_sample = (window_full && old_ok) ? ram_rdata : '0;

  assign x_sq_full   = head_sample * head_sample;
  assign old_sq_full = old_sample * old_sample;
  assign mag = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);

  // n*Q - S^2 >= (thr*n)^2, with the spread clamped at zero
  assign sigma_ge = (tnsq == '0) || (CMP_W'(nq) >= lim);
  assign n_ok     = (n >= WIN_W'(rsmg_pkg::MIN_SPREAD_N));
  assign quiet_inc = quiet_run + HOLD_W'(1);

  always_comb begin
    flag_next  = motion_flag;
    quiet_next = quiet_run;
    if (n_ok) begin
      if (motion_flag) begin
        if (!sigma_ge) begin
          if (quiet_inc >= cfg.exit_hold) begin
            flag_next  = 1'b0;
            quiet_next = '0;
          end else begin
            quiet_next = quiet_inc;
          end
        end else begin
          quiet_next = '0;
        end
      end else if (sigma_ge) begin
        flag_next  = 1'b1;
        quiet_next = '0;
      end
    end
    all_next    = all_samples + CNT_W'(1);
    motion_next = flag_next ? motion_samples + CNT_W'(1) : motion_samples;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsmg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    head_pop   = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    do_clear   = 1'b0;
    case (state)
      rsmg_pkg::ST_IDLE: begin
        if (head_valid) begin
          if (head_clear) begin
            if (!out_busy) begin
              head_pop = 1'b1;
              do_clear = 1'b1;
              load_out = 1'b1;
            end
          end else begin
            head_pop   = 1'b1;
            state_next = rsmg_pkg::ST_READ;
          end
        end
      end
      rsmg_pkg::ST_READ: begin
        ram_we     = 1'b1;
        state_next = rsmg_pkg::ST_ACC;
      end
      rsmg_pkg::ST_ACC: begin
        state_next = rsmg_pkg::ST_MUL;
      end
      rsmg_pkg::ST_MUL: begin
        state_next = rsmg_pkg::ST_CMP;
      end
      rsmg_pkg::ST_CMP: begin
        if (!out_busy) begin
          load_out   = 1'b1;
          state_next = rsmg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rsmg_pkg::ST_IDLE;
      end
    endcase
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      rsmg_pkg::ST_IDLE: begin
        x        <= head_sample;
        xsq      <= $unsigned(x_sq_full);
        pos_adv  <= wrap ? '0 : pos_inc[POS_W-1:0];
        full_adv <= window_full || wrap;
        n        <= n_calc;
        tn       <= TN_W'(thr_sel) * TN_W'(n_calc);
      end
      rsmg_pkg::ST_READ: begin
        old_sq <= $unsigned(old_sq_full);
        tnsq   <= TNSQ_W'(tn) * TNSQ_W'(tn);
      end
      rsmg_pkg::ST_ACC: begin
        magsq <= MSQ_W'(mag) * MSQ_W'(mag);
      end
      rsmg_pkg::ST_MUL: begin
        nq  <= NQ_W'(n) * NQ_W'(running_sq);
        lim <= CMP_W'(magsq) + CMP_W'(tnsq);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      position       <= '0;
      window_full    <= 1'b0;
      running_sum    <= '0;
      running_sq     <= '0;
      quiet_run      <= '0;
      motion_flag    <= 1'b0;
      motion_samples <= '0;
      all_samples    <= '0;
      fill_count     <= '0;
    end else begin
      case (state)
        rsmg_pkg::ST_READ: begin
          position    <= pos_adv;
          window_full <= full_adv;
          running_sum <= running_sum + SUM_W'(x) - SUM_W'(old_sample);
          if (pos_inc > fill_count) begin
            fill_count <= pos_inc;
          end
        end
        rsmg_pkg::ST_ACC: begin
          running_sq <= running_sq + SQ_W'(xsq) - SQ_W'(old_sq);
        end
        rsmg_pkg::ST_CMP: begin
          if (load_out) begin
            motion_flag    <= flag_next;
            quiet_run      <= quiet_next;
            motion_samples <= motion_next;
            all_samples    <= all_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      motion_on    <= do_clear ? 1'b0 : flag_next;
      motion_count <= do_clear ? '0 : motion_next;
      total_count  <= do_clear ? '0 : all_next;
    end
  end

  `RSMG_ASSERT_NOW(a_pop_idle, head_pop, (state == rsmg_pkg::ST_IDLE) && head_valid)
  `RSMG_ASSERT_NEXT(a_sample_reads, head_pop && !head_clear, state == rsmg_pkg::ST_READ)
  `RSMG_ASSERT_NEXT(a_cmp_loads, (state == rsmg_pkg::ST_CMP) && !out_busy, result_valid)
  `RSMG_ASSERT_NOW(a_flag_shown, result_valid, motion_on == motion_flag)

endmodule

### rtl/rolling_sigma_motion_gate_top.sv
// top level of the rolling sigma motion gate: configuration registers, front queue, back end
// depends on rsmg_pkg, rsmg_front, rsmg_core
//
//   channel   handshake                  payload
//   item      item_valid / item_stall    op, sample
//   result    result_valid / result_stall motion_on, motion_count, total_count
//   config    cfg_we                     cfg_index, cfg_data
//
// a sample holds the back end through pop and ring read, sum update,
// square-sum update, n*Q multiply, compare into the result register; a clear is applied at its pop
// the two-entry front queue takes beats while the back end is busy
// reset is synchronous; ring entries past the fill mark read as zero, so no clearing pass
// a held result stalls the back end only when the next result is ready
module rolling_sigma_motion_gate_top #(
  parameter int MAX_WINDOW  = rsmg_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = rsmg_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rsmg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsmg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               op,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               motion_on,
  output logic [rsmg_pkg::CNT_W-1:0]         motion_count,
  output logic [rsmg_pkg::CNT_W-1:0]         total_count
);

  rsmg_pkg::cfg_t cfg;

  logic                          head_valid;
  logic                          head_clear;
  logic signed [SAMPLE_BITS-1:0] head_sample;
  logic                          head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length <= rsmg_pkg::RST_WINDOW_LENGTH;
      cfg.enter_level   <= rsmg_pkg::RST_ENTER_THR;
      cfg.exit_level    <= rsmg_pkg::RST_EXIT_THR;
      cfg.exit_hold     <= rsmg_pkg::RST_EXIT_HOLD;
    end else if (cfg_we) begin
      case (rsmg_pkg::cfg_reg_t'(cfg_index))
        rsmg_pkg::REG_WINDOW_LENGTH: cfg.window_length <= cfg_data[rsmg_pkg::WL_W-1:0];
        rsmg_pkg::REG_ENTER_THR:     cfg.enter_level   <= cfg_data;
        rsmg_pkg::REG_EXIT_THR:      cfg.exit_level    <= cfg_data;
        rsmg_pkg::REG_EXIT_HOLD:     cfg.exit_hold     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rsmg_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .sample     (sample),
    .head_valid (head_valid),
    .head_clear (head_clear),
    .head_sample(head_sample),
    .head_pop   (head_pop)
  );

  rsmg_core #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_clear   (head_clear),
    .head_sample  (head_sample),
    .head_pop     (head_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .motion_on    (motion_on),
    .motion_count (motion_count),
    .total_count  (total_count)
  );

endmodule

### dv/tb_rolling_sigma_motion_gate_top.sv
// testbench for rolling_sigma_motion_gate_top: directed cases, then random phases of bursty
// sample streams; every result beat is checked against an in-bench predictor of the gate
// depends on rsmg_pkg and the rtl of rolling_sigma_motion_gate_top
module tb_rolling_sigma_motion_gate_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIN       = rsmg_pkg::DEF_MAX_WINDOW;
  localparam int SBITS         = rsmg_pkg::DEF_SAMPLE_BITS;
  localparam int CNT_W         = rsmg_pkg::CNT_W;
  localparam int CFG_IDX_W     = rsmg_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = rsmg_pkg::CFG_DATA_W;
  localparam int WL_W          = rsmg_pkg::WL_W;
  localparam int THR_W         = rsmg_pkg::THR_W;
  localparam int HOLD_W        = rsmg_pkg::HOLD_W;
  localparam int MIN_SPREAD_N  = rsmg_pkg::MIN_SPREAD_N;
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_CLEAR    = 1'b1;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int MAX_GAP       = 19;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_CAP    = 50;

  typedef struct packed {
    logic             motion_on;
    logic [CNT_W-1:0] motion_count;
    logic [CNT_W-1:0] total_count;
  } gate_out_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    item_valid;
  logic                    item_stall;
  logic                    item_op;
  logic signed [SBITS-1:0] item_sample;
  logic                    result_valid;
  logic                    result_stall;
  logic                    motion_on;
  logic [CNT_W-1:0]        motion_count;
  logic [CNT_W-1:0]        total_count;

  rolling_sigma_motion_gate_top #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(SBITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .op          (item_op),
    .sample      (item_sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .motion_on   (motion_on),
    .motion_count(motion_count),
    .total_count (total_count)
  );

  // predictor copy of the registers and the gate state
  logic [WL_W-1:0]         cfg_window;
  logic [THR_W-1:0]        cfg_enter;
  logic [THR_W-1:0]        cfg_exit;
  logic [HOLD_W-1:0]       cfg_hold;
  logic signed [SBITS-1:0] ring_copy [MAX_WIN];
  int                      wr_pos;
  bit                      win_full;
  longint                  run_sum;
  longint                  run_sq;
  int unsigned             quiet_run;
  bit                      gate_open;
  logic [CNT_W-1:0]        motion_seen;
  logic [CNT_W-1:0]        seen_total;

  gate_out_t gate_outputs_due [$];
  int        fail_count = 0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic longint effective_window(input logic [WL_W-1:0] w);
    if (w < 1) return 1;
    if (w > MAX_WIN) return MAX_WIN;
    return longint'(w);
  endfunction

  // sigma >= thr  <=>  spread >= (thr*n)^2
  function automatic bit sigma_reaches(input longint spread, input longint n,
                                       input longint thr);
    longint tn;
    tn = thr * n;
    return spread >= tn * tn;
  endfunction

  function automatic void clear_gate_state();
    foreach (ring_copy[i]) ring_copy[i] = '0;
    wr_pos      = 0;
    win_full    = 1'b0;
    run_sum     = 0;
    run_sq      = 0;
    quiet_run   = 0;
    gate_open   = 1'b0;
    motion_seen = '0;
    seen_total  = '0;
  endfunction

  function automatic gate_out_t next_gate_output(input logic op_in,
                                                 input logic signed [SBITS-1:0] smp);
    longint    win;
    longint    pos;
    longint    n;
    longint    x;
    longint    old;
    longint    spread;
    gate_out_t res;
    win = effective_window(cfg_window);
    if (op_in == OP_CLEAR) begin
      clear_gate_state();
    end else begin
      x   = smp;
      pos = wr_pos % MAX_WIN;
      old = ring_copy[pos];
      if (win_full) begin
        run_sum += x - old;
        run_sq  += x * x - old * old;
      end else begin
        run_sum += x;
        run_sq  += x * x;
      end
      ring_copy[pos] = smp;
      pos++;
      if (pos >= win) begin
        pos      = 0;
        win_full = 1'b1;
      end
      wr_pos = int'(pos);
      n      = win_full ? win : pos;
      seen_total++;
      if (n >= MIN_SPREAD_N) begin
        spread = n * run_sq - run_sum * run_sum;
        if (spread < 0) spread = 0;
        if (gate_open) begin
          if (!sigma_reaches(spread, n, cfg_exit)) begin
            quiet_run++;
            if (quiet_run >= cfg_hold) begin
              gate_open = 1'b0;
              quiet_run = 0;
            end
          end else begin
            quiet_run = 0;
          end
        end else if (sigma_reaches(spread, n, cfg_enter)) begin
          gate_open = 1'b1;
          quiet_run = 0;
        end
      end
      if (gate_open) motion_seen++;
    end
    res.motion_on    = gate_open;
    res.motion_count = motion_seen;
    res.total_count  = seen_total;
    return res;
  endfunction

  // valid stays high after a beat so back-to-back beats need no second assignment
  task automatic send_item(input logic op_in, input logic signed [SBITS-1:0] smp);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    item_op     <= op_in;
    item_sample <= smp;
    do @(posedge clk); while (item_stall);
    gate_outputs_due.push_back(next_gate_output(op_in, smp));
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (gate_outputs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input rsmg_pkg::cfg_reg_t idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      rsmg_pkg::REG_WINDOW_LENGTH: cfg_window = value[WL_W-1:0];
      rsmg_pkg::REG_ENTER_THR:     cfg_enter  = value;
      rsmg_pkg::REG_EXIT_THR:      cfg_exit   = value;
      rsmg_pkg::REG_EXIT_HOLD:     cfg_hold   = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_gate_config(input logic [WL_W-1:0] wl, input logic [THR_W-1:0] enter_thr,
                                 input logic [THR_W-1:0] exit_thr,
                                 input logic [HOLD_W-1:0] hold);
    write_reg(rsmg_pkg::REG_WINDOW_LENGTH, {{(CFG_DATA_W-WL_W){1'b0}}, wl});
    write_reg(rsmg_pkg::REG_ENTER_THR, enter_thr);
    write_reg(rsmg_pkg::REG_EXIT_THR, exit_thr);
    write_reg(rsmg_pkg::REG_EXIT_HOLD, hold);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return THR_W'($urandom_range(0, 65535));
      default: return THR_W'($urandom_range(0, 3000));
    endcase
  endfunction

  initial begin : result_sink
    int        hold_cycles;
    int        beat_no;
    gate_out_t due;
    beat_no = 0;
    forever begin
      hold_cycles = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (rst || !result_valid);
      if (gate_outputs_due.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", beat_no));
      end else begin
        due = gate_outputs_due.pop_front();
        if (motion_on !== due.motion_on)
          report_mismatch($sformatf("beat %0d motion_on %b, want %b",
                                    beat_no, motion_on, due.motion_on));
        if (motion_count !== due.motion_count)
          report_mismatch($sformatf("beat %0d motion_count %0d, want %0d",
                                    beat_no, motion_count, due.motion_count));
        if (total_count !== due.total_count)
          report_mismatch($sformatf("beat %0d total_count %0d, want %0d",
                                    beat_no, total_count, due.total_count));
      end
      beat_no++;
    end
  end

  // reset values; single sample holds the flag, then extreme swing enters motion
  task automatic test_defaults();
    send_item(OP_SAMPLE, 16'sh7FFF);
    send_item(OP_SAMPLE, -16'sd32768);
    send_item(OP_CLEAR, 16'sh5A5A);
  endtask

  // zero hold: the first quiet beat in motion leaves motion
  task automatic test_zero_hold();
    drain_results();
    set_gate_config(8'd2, 16'd100, 16'd50, 16'd0);
    send_item(OP_SAMPLE, 16'sd1000);
    send_item(OP_SAMPLE, -16'sd1000);
    send_item(OP_SAMPLE, 16'sd5);
    send_item(OP_SAMPLE, 16'sd5);
  endtask

  // exit threshold above enter threshold
  task automatic test_exit_above_enter();
    drain_results();
    set_gate_config(8'd4, 16'd200, 16'd400, 16'd3);
    send_item(OP_CLEAR, '0);
    send_item(OP_SAMPLE, 16'sd300);
    send_item(OP_SAMPLE, -16'sd300);
    send_item(OP_SAMPLE, 16'sd0);
  endtask

  // window 0 acts as 1 and holds the flag; window 255 acts as the maximum
  task automatic test_window_limits();
    drain_results();
    set_gate_config(8'd2, 16'd0, 16'hFFFF, 16'hFFFF);
    send_item(OP_CLEAR, '0);
    send_item(OP_SAMPLE, 16'sd7);
    send_item(OP_SAMPLE, 16'sd7);
    drain_results();
    set_gate_config(8'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_item(OP_SAMPLE, 16'sd100);
    send_item(OP_SAMPLE, -16'sd100);
    drain_results();
    set_gate_config(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_CLEAR, '1);
    send_item(OP_SAMPLE, -16'sd32768);
    send_item(OP_SAMPLE, 16'sh7FFF);
  endtask

  // shrinking a full window leaves stale entries in the sums: spread goes negative
  task automatic test_window_shrink();
    drain_results();
    set_gate_config(8'd4, 16'hFFFF, 16'd0, 16'hFFFF);
    send_item(OP_CLEAR, '0);
    repeat (4) send_item(OP_SAMPLE, 16'sd1000);
    drain_results();
    set_gate_config(8'd2, 16'd0, 16'd0, 16'd1);
    send_item(OP_SAMPLE, 16'sd0);
    send_item(OP_SAMPLE, 16'sd0);
  endtask

  // phases of quiet and loud bursts under random settings
  task automatic test_random_phases();
    int              sent;
    int              phase_len;
    int              burst_left;
    int              amp;
    int              base;
    int              v;
    int              pick;
    bit              loud;
    logic [WL_W-1:0] wl;
    logic [HOLD_W-1:0] hold;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(0, 9))
        0:       wl = 8'd0;
        1:       wl = 8'd1;
        2:       wl = 8'd128;
        3:       wl = 8'd255;
        4:       wl = WL_W'($urandom_range(17, 127));
        default: wl = WL_W'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 7))
        0:       hold = '0;
        1:       hold = '1;
        2:       hold = HOLD_W'($urandom_range(0, 65535));
        default: hold = HOLD_W'($urandom_range(1, 12));
      endcase
      set_gate_config(wl, pick_threshold(), pick_threshold(), hold);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        send_item(OP_CLEAR, SBITS'($urandom_range(0, 65535)));
        sent++;
      end
      phase_len  = $urandom_range(40, 120);
      loud       = ($urandom_range(0, 1) != 0);
      burst_left = 0;
      amp        = 0;
      base       = 0;
      repeat (phase_len) begin
        if (burst_left == 0) begin
          loud       = !loud;
          burst_left = $urandom_range(1, 30);
          if (loud) begin
            amp  = $urandom_range(1000, 32767);
            base = 0;
          end else begin
            amp  = $urandom_range(0, 300);
            base = int'($urandom_range(0, 40000)) - 20000;
          end
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          send_item(OP_CLEAR, SBITS'($urandom_range(0, 65535)));
        end else if (pick < 7) begin
          send_item(OP_SAMPLE, SBITS'($urandom_range(0, 65535)));
        end else begin
          v = base + int'($urandom_range(0, 2 * amp)) - amp;
          if (loud && $urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 32767 : -32768;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          send_item(OP_SAMPLE, SBITS'(v));
        end
        // occasional hold-off until the pipeline is empty
        if ($urandom_range(0, 199) == 0) drain_results();
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= rsmg_pkg::REG_WINDOW_LENGTH;
    cfg_data    <= '0;
    item_valid  <= 1'b0;
    item_op     <= OP_SAMPLE;
    item_sample <= '0;
    cfg_window  = rsmg_pkg::RST_WINDOW_LENGTH;
    cfg_enter   = rsmg_pkg::RST_ENTER_THR;
    cfg_exit    = rsmg_pkg::RST_EXIT_THR;
    cfg_hold    = rsmg_pkg::RST_EXIT_HOLD;
    clear_gate_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_zero_hold();
    test_exit_above_enter();
    test_window_limits();
    test_window_shrink();
    test_random_phases();

    item_valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && gate_outputs_due.size() != 0; i++) @(posedge clk);
    if (gate_outputs_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", gate_outputs_due.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rsmg_pkg.sv
rtl/rsmg_ram.sv
rtl/rsmg_front.sv
rtl/rsmg_core.sv
rtl/rolling_sigma_motion_gate_top.sv
dv/tb_rolling_sigma_motion_gate_top.sv
